### hw/rtl/bst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

  // Field widths
  localparam int unsigned CoordW  = 40;
  localparam int unsigned DiffW   = 41;
  localparam int unsigned LenW    = 41;
  localparam int unsigned StrainW = 40;
  localparam int unsigned SqW     = 82;
  localparam int unsigned RemW    = 42;
  localparam int unsigned NumW    = 73;
  localparam int unsigned FracW   = 32;

  // Shared adder width
  localparam int unsigned AluW = 84;

  // Step counter
  localparam int unsigned CntW = 7;
  localparam logic [CntW-1:0] SqLast = CntW'(40);
  localparam logic [CntW-1:0] RtLast = CntW'(40);
  localparam logic [CntW-1:0] DvLast = CntW'(72);

  // Saturation limits
  localparam logic [StrainW-1:0] StrainMaxPos = {1'b0, {(StrainW-1){1'b1}}};
  localparam logic [StrainW-1:0] StrainMagNeg = {1'b1, {(StrainW-1){1'b0}}};

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DX,
    ST_NX,
    ST_DY,
    ST_NY,
    ST_SQX,
    ST_SQY,
    ST_RT,
    ST_CHK,
    ST_DM1,
    ST_DM2,
    ST_DV,
    ST_SAT,
    ST_DONE
  } state_e;

  // Sequencer to datapath
  typedef struct packed {
    state_e state;
    logic   last;
    logic   ready;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic need_div;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/bst_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module bst_alu import bst_pkg::*; (
  input  wire logic [AluW-1:0] a_i,
  input  wire logic [AluW-1:0] b_i,
  input  wire logic            sub_i,
  output logic      [AluW-1:0] res_o,
  output logic                 nb_o
);

  logic [AluW:0] sum;

  // Add, or subtract through the inverted operand with carry in
  always_comb begin
    sum   = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)} + {{AluW{1'b0}}, sub_i};
    res_o = sum[AluW-1:0];
    nb_o  = sum[AluW];
  end

endmodule

`default_nettype wire

### hw/rtl/bst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bst_ctrl import bst_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            last;

  assign last = (cnt_q == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_DX;
      ST_DX:   state_d = ST_NX;
      ST_NX:   state_d = ST_DY;
      ST_DY:   state_d = ST_NY;
      ST_NY:   state_d = ST_SQX;
      ST_SQX:  if (last) state_d = ST_SQY;
      ST_SQY:  if (last) state_d = ST_RT;
      ST_RT:   if (last) state_d = ST_CHK;
      ST_CHK:  state_d = stat_i.need_div ? ST_DM1 : ST_DONE;
      ST_DM1:  state_d = ST_DM2;
      ST_DM2:  state_d = ST_DV;
      ST_DV:   if (last) state_d = ST_SAT;
      ST_SAT:  state_d = ST_DONE;
      ST_DONE: if (stat_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Step counter: load on entry to a long phase, count down inside it
  always_comb begin
    cnt_d = cnt_q - CntW'(1);
    case (state_q)
      ST_NY:   cnt_d = SqLast;
      ST_SQX:  cnt_d = last ? SqLast : cnt_q - CntW'(1);
      ST_SQY:  cnt_d = last ? RtLast : cnt_q - CntW'(1);
      ST_DM2:  cnt_d = DvLast;
      ST_RT, ST_DV: cnt_d = cnt_q - CntW'(1);
      default: cnt_d = '0;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o.state = state_q;
    ctrl_o.last  = last;
    ctrl_o.ready = (state_q == ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/baseline_strain_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Baseline strain tracker.
// One input transaction is one survey epoch: two points, x/y each, on the
// slave stream, with tuser marking the first epoch of a new series. One
// output transaction per epoch carries the floor of the point distance and
// the relative length change against the previous epoch, 32 fraction bits.
// Tuser flags tell whether the strain is valid and whether the previous
// length was zero.
// All arithmetic runs through one shared 84-bit adder under a sequencer:
// the differences and their magnitudes, shift-add squaring, the square
// root, then long division when a strain is due against a nonzero previous
// length; division is skipped for a first epoch or a zero base. The result
// then enters the output register, and the next input transaction can be
// taken from the cycle after that on.
// The output register holds a result while the receiver stalls; the next
// epoch is accepted meanwhile and waits in its final step until the register
// is free.
// Reset empties the output register and forgets the previous length, so the
// first epoch after reset carries no strain.

module baseline_strain_tracker import bst_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // first_x[39:0], first_y[79:40], second_x[119:80], second_y[159:120]
  input  wire logic [159:0] s_axis_tdata,
  // restart[0]
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // baseline_length[40:0], strain[80:41], zero fill[87:81]
  output logic [87:0]       m_axis_tdata,
  // strain_valid[0], zero_base[1]
  output logic [1:0]        m_axis_tuser
);

  ctrl_t ctrl;
  stat_t stat;
  logic  start;

  // Captured epoch
  logic [CoordW-1:0] fx_q, fy_q, sx_q, sy_q;
  logic              restart_q;

  // Working registers
  logic [DiffW-1:0]   ax_q, ay_q;
  logic [DiffW-1:0]   m_q;
  logic [SqW-1:0]     mc_q, acc_q;
  logic [RemW-1:0]    rem_q;
  logic [LenW-1:0]    root_q;
  logic               neg_q, over_q;
  logic [NumW-1:0]    num_q;
  logic [LenW-1:0]    drem_q;
  logic [StrainW-1:0] quo_q, strain_q, qsat;
  logic               sv_q, zb_q;

  // Series state
  logic [LenW-1:0] prev_q;
  logic            have_prev_q;

  // Output register
  logic               out_valid_q;
  logic [LenW-1:0]    out_len_q;
  logic [StrainW-1:0] out_strain_q;
  logic               out_sv_q, out_zb_q;

  // Shared adder
  logic [AluW-1:0] alu_a, alu_b, alu_res;
  logic            alu_sub, alu_nb;

  assign start          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready  = ctrl.ready;
  assign stat.out_free  = !out_valid_q || m_axis_tready;
  assign stat.need_div  = !restart_q && have_prev_q && (prev_q != '0);

  bst_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl)
  );

  bst_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .nb_o  (alu_nb)
  );

  // Saturate the quotient magnitude
  always_comb begin
    if (neg_q) begin
      qsat = (over_q || (quo_q[StrainW-1] && (quo_q[StrainW-2:0] != '0))) ?
             StrainMagNeg : quo_q;
    end else begin
      qsat = (over_q || quo_q[StrainW-1]) ? StrainMaxPos : quo_q;
    end
  end

  // Select adder operands per step
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (ctrl.state)
      ST_DX: begin
        alu_a   = {{(AluW-CoordW){sx_q[CoordW-1]}}, sx_q};
        alu_b   = {{(AluW-CoordW){fx_q[CoordW-1]}}, fx_q};
        alu_sub = 1'b1;
      end
      ST_DY: begin
        alu_a   = {{(AluW-CoordW){sy_q[CoordW-1]}}, sy_q};
        alu_b   = {{(AluW-CoordW){fy_q[CoordW-1]}}, fy_q};
        alu_sub = 1'b1;
      end
      ST_NX: begin
        alu_b   = {{(AluW-DiffW){ax_q[DiffW-1]}}, ax_q};
        alu_sub = 1'b1;
      end
      ST_NY: begin
        alu_b   = {{(AluW-DiffW){ay_q[DiffW-1]}}, ay_q};
        alu_sub = 1'b1;
      end
      ST_SQX, ST_SQY: begin
        alu_a = {{(AluW-SqW){1'b0}}, acc_q};
        alu_b = {{(AluW-SqW){1'b0}}, mc_q};
      end
      ST_RT: begin
        alu_a   = {{(AluW-RemW-2){1'b0}}, rem_q, acc_q[SqW-1:SqW-2]};
        alu_b   = {{(AluW-LenW-2){1'b0}}, root_q, 2'b01};
        alu_sub = 1'b1;
      end
      ST_DM1: begin
        alu_a   = {{(AluW-LenW){1'b0}}, root_q};
        alu_b   = {{(AluW-LenW){1'b0}}, prev_q};
        alu_sub = 1'b1;
      end
      ST_DM2: begin
        alu_a   = {{(AluW-LenW){1'b0}}, (neg_q ? prev_q : root_q)};
        alu_b   = {{(AluW-LenW){1'b0}}, (neg_q ? root_q : prev_q)};
        alu_sub = 1'b1;
      end
      ST_DV: begin
        alu_a   = {{(AluW-LenW-1){1'b0}}, drem_q, num_q[NumW-1]};
        alu_b   = {{(AluW-LenW){1'b0}}, prev_q};
        alu_sub = 1'b1;
      end
      ST_SAT: begin
        alu_b   = {{(AluW-StrainW){1'b0}}, qsat};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      fx_q      <= s_axis_tdata[39:0];
      fy_q      <= s_axis_tdata[79:40];
      sx_q      <= s_axis_tdata[119:80];
      sy_q      <= s_axis_tdata[159:120];
      restart_q <= s_axis_tuser[0];
    end
    case (ctrl.state)
      ST_DX: ax_q <= alu_res[DiffW-1:0];
      ST_DY: ay_q <= alu_res[DiffW-1:0];
      // Take the magnitude of the x difference
      ST_NX: if (ax_q[DiffW-1]) ax_q <= alu_res[DiffW-1:0];
      // Take the magnitude of the y difference, then start the x square
      ST_NY: begin
        if (ay_q[DiffW-1]) ay_q <= alu_res[DiffW-1:0];
        m_q   <= ax_q;
        mc_q  <= {{(SqW-DiffW){1'b0}}, ax_q};
        acc_q <= '0;
      end
      // Shift-add squaring; switch to y after the last x step
      ST_SQX, ST_SQY: begin
        if (m_q[0]) acc_q <= alu_res[SqW-1:0];
        if ((ctrl.state == ST_SQX) && ctrl.last) begin
          m_q  <= ay_q;
          mc_q <= {{(SqW-DiffW){1'b0}}, ay_q};
        end else begin
          m_q  <= m_q >> 1;
          mc_q <= mc_q << 1;
        end
        if ((ctrl.state == ST_SQY) && ctrl.last) begin
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      // One root bit per step, two radicand bits shifted in
      ST_RT: begin
        acc_q <= acc_q << 2;
        if (alu_nb) begin
          rem_q  <= alu_res[RemW-1:0];
          root_q <= {root_q[LenW-2:0], 1'b1};
        end else begin
          rem_q  <= {rem_q[RemW-3:0], acc_q[SqW-1:SqW-2]};
          root_q <= {root_q[LenW-2:0], 1'b0};
        end
      end
      // Decide the flags; strain stays zero unless divided
      ST_CHK: begin
        sv_q     <= !restart_q && have_prev_q;
        zb_q     <= !restart_q && have_prev_q && (prev_q == '0);
        strain_q <= '0;
      end
      ST_DM1: neg_q <= !alu_nb;
      ST_DM2: begin
        num_q  <= {alu_res[LenW-1:0], {FracW{1'b0}}};
        drem_q <= '0;
        quo_q  <= '0;
        over_q <= 1'b0;
      end
      // Restoring division, one quotient bit per step
      ST_DV: begin
        num_q  <= num_q << 1;
        drem_q <= alu_nb ? alu_res[LenW-1:0] : alu_a[LenW-1:0];
        quo_q  <= {quo_q[StrainW-2:0], alu_nb};
        over_q <= over_q || quo_q[StrainW-1];
      end
      ST_SAT: strain_q <= neg_q ? alu_res[StrainW-1:0] : qsat;
      default: begin
      end
    endcase
  end

  // Series state: every epoch loaded into the output register becomes the new reference
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else if ((ctrl.state == ST_DONE) && stat.out_free) begin
      prev_q      <= root_q;
      have_prev_q <= 1'b1;
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((ctrl.state == ST_DONE) && stat.out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((ctrl.state == ST_DONE) && stat.out_free) begin
      out_len_q    <= root_q;
      out_strain_q <= strain_q;
      out_sv_q     <= sv_q;
      out_zb_q     <= zb_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_strain_q, out_len_q};
  assign m_axis_tuser  = {out_zb_q, out_sv_q};

endmodule

`default_nettype wire

### tb/tb_baseline_strain_tracker.sv
`timescale 1ns / 1ps

module tb_baseline_strain_tracker;
  import bst_pkg::*;

  localparam int unsigned LongHold   = 1500;
  localparam int unsigned QuietLimit = 6000;
  localparam int unsigned RandEpochs = 500;
  localparam int unsigned TailCycles = 250;

  localparam logic [CoordW-1:0] CoordMin  = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [CoordW-1:0] CoordMax  = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] CoordOnes = {CoordW{1'b1}};

  typedef struct packed {
    logic [CoordW-1:0] first_x;
    logic [CoordW-1:0] first_y;
    logic [CoordW-1:0] second_x;
    logic [CoordW-1:0] second_y;
    logic              restart;
  } epoch_t;

  typedef struct packed {
    logic [LenW-1:0]    length;
    logic [StrainW-1:0] strain;
    logic               strain_valid;
    logic               zero_base;
  } strain_result_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  // Track the series length and hold the strain results still owed by the block
  class strain_scoreboard;
    logic [LenW-1:0] last_length = '0;
    bit              have_last   = 1'b0;
    strain_result_t  pending[$];
    int unsigned     errors      = 0;

    // Floor of the point distance, exact integer square root
    function logic [LenW-1:0] floor_distance(epoch_t e);
      logic signed [DiffW-1:0] dx, dy;
      logic [DiffW-1:0] ax, ay;
      logic [83:0] sum;
      logic [41:0] root, cand;
      dx = $signed({e.second_x[CoordW-1], e.second_x}) - $signed({e.first_x[CoordW-1], e.first_x});
      dy = $signed({e.second_y[CoordW-1], e.second_y}) - $signed({e.first_y[CoordW-1], e.first_y});
      ax = dx[DiffW-1] ? -dx : dx;
      ay = dy[DiffW-1] ? -dy : dy;
      sum = 84'(ax) * 84'(ax) + 84'(ay) * 84'(ay);
      root = '0;
      for (int b = 41; b >= 0; b--) begin
        cand = root | (42'd1 << b);
        if (84'(cand) * 84'(cand) <= sum) root = cand;
      end
      return root[LenW-1:0];
    endfunction

    // (cur - prev) / prev with 32 fraction bits, truncated toward zero, saturated
    function logic [StrainW-1:0] relative_change(logic [LenW-1:0] cur, logic [LenW-1:0] prev);
      logic [127:0] num, quo;
      logic neg;
      neg = cur < prev;
      num = neg ? 128'(prev - cur) : 128'(cur - prev);
      num = num << FracW;
      quo = num / 128'(prev);
      if (neg) begin
        if (quo > 128'(StrainMagNeg)) quo = 128'(StrainMagNeg);
        return StrainW'(128'd0 - quo);
      end
      if (quo > 128'(StrainMaxPos)) quo = 128'(StrainMaxPos);
      return quo[StrainW-1:0];
    endfunction

    function void note_epoch(epoch_t e);
      strain_result_t r;
      r.length       = floor_distance(e);
      r.strain       = '0;
      r.strain_valid = 1'b0;
      r.zero_base    = 1'b0;
      if (!e.restart && have_last) begin
        r.strain_valid = 1'b1;
        if (last_length == '0) r.zero_base = 1'b1;
        else r.strain = relative_change(r.length, last_length);
      end
      last_length = r.length;
      have_last   = 1'b1;
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [87:0] data, logic [1:0] flags);
      strain_result_t want;
      if (pending.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual data 0x%0h flags %b",
                 $time, data, flags);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("baseline_length", 64'(want.length), 64'(data[40:0]));
      compare_field("strain", 64'(want.strain), 64'(data[80:41]));
      compare_field("strain_valid", 64'(want.strain_valid), 64'(flags[0]));
      compare_field("zero_base", 64'(want.zero_base), 64'(flags[1]));
    endfunction
  endclass

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata  = '0;
  logic [0:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  strain_scoreboard sb = new();

  epoch_t offered;
  assign offered = {s_axis_tdata[39:0], s_axis_tdata[79:40], s_axis_tdata[119:80],
                    s_axis_tdata[159:120], s_axis_tuser[0]};

  baseline_strain_tracker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Note accepted epochs and check accepted results
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_epoch(offered);
  end

  // Abort when no transaction moves for too long
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: switch between stall patterns, and hold off on request
  rx_mode_e    rx_mode     = RX_OPEN;
  int unsigned rx_stretch  = 0;
  int unsigned hold_left   = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done  = 0;
  logic [2:0]  rx_phase    = '0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      m_axis_tready <= 1'b0;
      holds_done    <= holds_done + 1;
      hold_left     <= LongHold;
    end else begin
      if (rx_stretch == 0) begin
        rx_mode    <= rx_mode_e'($urandom_range(0, 3));
        rx_stretch <= $urandom_range(20, 400);
      end else begin
        rx_stretch <= rx_stretch - 1;
      end
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= (rx_phase[1:0] != 2'b11);
      endcase
      rx_phase <= rx_phase + 3'd1;
    end
  end

  // Sender state
  int unsigned burst_left  = 0;
  int unsigned keep_busy   = 0;
  bit          series_live = 1'b0;
  epoch_t      series_epoch;

  // Offer one epoch and wait for its transaction
  task automatic send_epoch(epoch_t e);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {e.second_y, e.second_x, e.first_y, e.first_x};
    s_axis_tuser  <= e.restart;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drop valid for a random gap once a burst runs out
  task automatic idle_between();
    if (keep_busy != 0) begin
      keep_busy--;
    end else if (burst_left != 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 300)) @(posedge clk_i);
      burst_left = $urandom_range(0, 10);
    end
  endtask

  // Stop offering until every owed result has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
  endtask

  task automatic directed(logic [CoordW-1:0] fx, logic [CoordW-1:0] fy,
                          logic [CoordW-1:0] sx, logic [CoordW-1:0] sy, logic restart);
    epoch_t e;
    e = {fx, fy, sx, sy, restart};
    send_epoch(e);
    idle_between();
  endtask

  // Signed coordinate with magnitude at most 2^(w-1)
  function automatic logic [CoordW-1:0] rand_coord(int unsigned w);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return CoordW'($signed(r[CoordW-1:0]) >>> (CoordW - w));
  endfunction

  // Move a coordinate, leave it alone where it would leave the field range
  function automatic logic [CoordW-1:0] shift_coord(logic [CoordW-1:0] c, logic [CoordW-1:0] d);
    logic [CoordW:0] s;
    s = {c[CoordW-1], c} + {d[CoordW-1], d};
    return (s[CoordW] != s[CoordW-1]) ? c : s[CoordW-1:0];
  endfunction

  // Mostly continue a series with small moves; sometimes start one or send noise
  task automatic next_random_epoch(output epoch_t e);
    int unsigned pick, w;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      e.first_x  = rand_coord(CoordW);
      e.first_y  = rand_coord(CoordW);
      e.second_x = rand_coord(CoordW);
      e.second_y = rand_coord(CoordW);
      e.restart  = 1'($urandom_range(0, 1));
    end else if (pick < 20) begin
      e.first_x  = rand_coord($urandom_range(1, 3));
      e.first_y  = rand_coord($urandom_range(1, 3));
      e.second_x = rand_coord($urandom_range(1, 3));
      e.second_y = rand_coord($urandom_range(1, 3));
      e.restart  = ($urandom_range(0, 7) == 0);
    end else if (!series_live || $urandom_range(0, 19) == 0) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(21, CoordW) : $urandom_range(1, 20);
      e.first_x  = rand_coord($urandom_range(1, CoordW));
      e.first_y  = rand_coord($urandom_range(1, CoordW));
      e.second_x = shift_coord(e.first_x, rand_coord(w));
      e.second_y = shift_coord(e.first_y, rand_coord(w));
      e.restart  = ($urandom_range(0, 3) != 0);
    end else begin
      e = series_epoch;
      w = $urandom_range(1, 6);
      e.second_x = shift_coord(e.second_x, rand_coord(w));
      e.second_y = shift_coord(e.second_y, rand_coord(w));
      if ($urandom_range(0, 3) == 0) e.first_x = shift_coord(e.first_x, rand_coord(w));
      e.restart = 1'b0;
    end
    series_epoch = e;
    series_live  = 1'b1;
  endtask

  initial begin
    epoch_t e;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First epoch after reset, then a zero previous length
    directed('0, '0, '0, '0, 1'b0);
    directed('0, '0, 40'd3, 40'd4, 1'b0);
    directed('0, '0, 40'd6, 40'd8, 1'b0);
    // Widest spread in both axes, then the same spread reversed
    directed(CoordMin, CoordMin, CoordMax, CoordMax, 1'b0);
    directed(CoordMax, CoordMax, CoordMin, CoordMin, 1'b0);
    directed(CoordMax, CoordMin, CoordMin, CoordMax, 1'b0);
    // Collapse to unit length, then growth right at the saturation edge
    directed('0, '0, 40'd1, '0, 1'b0);
    directed('0, '0, 40'd129, '0, 1'b0);
    directed('0, '0, 40'd1, '0, 1'b1);
    directed('0, '0, 40'd128, '0, 1'b0);
    // Truncation of a negative fraction
    directed('0, '0, 40'd3, '0, 1'b0);
    directed('0, '0, 40'd2, '0, 1'b0);
    // Shrink to zero, then zero again
    directed(CoordOnes, CoordOnes, CoordOnes, CoordOnes, 1'b0);
    directed(40'd1, 40'd1, 40'd1, 40'd1, 1'b0);
    // Non-square sums round down
    directed('0, '0, 40'd1, 40'd1, 1'b1);
    directed('0, '0, 40'd2, 40'd2, 1'b0);
    directed(CoordMin, '0, CoordMax, '0, 1'b0);
    directed('0, CoordMax, '0, CoordMin, 1'b1);
    drain_results();

    for (int unsigned i = 0; i < RandEpochs; i++) begin
      next_random_epoch(e);
      send_epoch(e);
      // Hold the receiver off while epochs keep coming
      if (i == 200) begin
        holds_asked <= holds_asked + 1;
        keep_busy = 8;
      end
      if (i == 350) drain_results();
      else idle_between();
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
